/* hdl/stk_pkg.sv */
// stk_pkg: shared types and constants for the value stack
// no dependencies; compiled before every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package stk_pkg;

  localparam int unsigned StackDepthDef = 128;
  localparam int unsigned ValueW        = 64;
  localparam int unsigned ActionW       = 3;
  localparam int unsigned StatusW       = 2;
  localparam int unsigned DepthW        = 8;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_TOP   = 3'd2,
    ACT_DUP   = 3'd3,
    ACT_SWAP  = 3'd4,
    ACT_CLEAR = 3'd5
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // what a cell loads this cycle
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_DOWN = 2'd1,
    CELL_UP   = 2'd2,
    CELL_ZERO = 2'd3
  } cell_op_e;

  // command broadcast from the controller to the cell row
  typedef struct packed {
    cell_op_e            op_top;
    cell_op_e            op_second;
    cell_op_e            op_rest;
    logic [ValueW-1:0]   feed;
  } cmd_t;

  typedef struct packed {
    logic [ValueW-1:0]  read_value;
    status_e            status;
    logic [DepthW-1:0]  depth;
  } res_t;

endpackage

`default_nettype wire

/* hdl/stk_if.sv */
// stk_in_if / stk_out_if: valid-ready channels for action and result beats
// depends on stk_pkg
`timescale 1ns / 1ps
`default_nettype none

interface stk_in_if;
  import stk_pkg::*;
  logic                valid;
  logic                ready;
  logic [ActionW-1:0]  action;
  logic [ValueW-1:0]   push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface stk_out_if;
  import stk_pkg::*;
  logic                valid;
  logic                ready;
  logic [ValueW-1:0]   read_value;
  logic [StatusW-1:0]  status;
  logic [DepthW-1:0]   depth;

  modport source (output valid, output read_value, output status, output depth,
                  input ready);
  modport sink   (input valid, input read_value, input status, input depth,
                  output ready);
endinterface

`default_nettype wire

/* hdl/stk_cell.sv */
// stk_cell: one stack slot; loads from the slot above, the slot below, loads zero or holds
// depends on stk_pkg
`timescale 1ns / 1ps
`default_nettype none

module stk_cell import stk_pkg::*; (
  input  wire logic               clk_i,
  input  wire cell_op_e           op_i,
  input  wire logic [ValueW-1:0]  above_i,
  input  wire logic [ValueW-1:0]  below_i,
  output logic      [ValueW-1:0]  data_o
);

  logic [ValueW-1:0] data_q, data_d;

  always_comb begin
    unique case (op_i)
      CELL_DOWN: data_d = above_i;
      CELL_UP:   data_d = below_i;
      CELL_ZERO: data_d = '0;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

/* hdl/stk_ctrl.sv */
// stk_ctrl: stack pointer and action decode driving the cell row
// depends on stk_pkg
`timescale 1ns / 1ps
`default_nettype none

module stk_ctrl import stk_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [ActionW-1:0]  action_i,
  input  wire logic [ValueW-1:0]   push_value_i,
  input  wire logic [ValueW-1:0]   top_i,
  output cmd_t                     cmd_o,
  output res_t                     res_o
);

  localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);

  logic [SpW-1:0] sp_q, sp_d;
  logic           empty, full;

  assign empty = (sp_q == '0);
  assign full  = (sp_q == SpW'(STACK_DEPTH));

  always_comb begin
    cmd_o.op_top     = CELL_HOLD;
    cmd_o.op_second  = CELL_HOLD;
    cmd_o.op_rest    = CELL_HOLD;
    cmd_o.feed       = '0;
    sp_d             = sp_q;
    res_o.read_value = '0;
    res_o.status     = ST_OK;
    if (accept_i) begin
      unique case (action_e'(action_i))
        ACT_PUSH: begin
          if (full) begin
            res_o.status = ST_FULL;
          end else begin
            cmd_o.op_top    = CELL_DOWN;
            cmd_o.op_second = CELL_DOWN;
            cmd_o.op_rest   = CELL_DOWN;
            cmd_o.feed      = push_value_i;
            sp_d            = sp_q + 1'b1;
          end
        end
        ACT_POP: begin
          if (empty) begin
            res_o.status = ST_EMPTY;
          end else begin
            res_o.read_value = top_i;
            cmd_o.op_top     = CELL_UP;
            cmd_o.op_second  = CELL_UP;
            cmd_o.op_rest    = CELL_UP;
            sp_d             = sp_q - 1'b1;
          end
        end
        ACT_TOP: begin
          if (empty) begin
            res_o.status = ST_EMPTY;
          end else begin
            res_o.read_value = top_i;
          end
        end
        ACT_DUP: begin
          // empty: a zero goes on top
          if (empty) begin
            res_o.status    = ST_EMPTY;
            cmd_o.op_top    = CELL_DOWN;
            cmd_o.op_second = CELL_DOWN;
            cmd_o.op_rest   = CELL_DOWN;
            sp_d            = SpW'(1);
          end else if (full) begin
            res_o.status = ST_FULL;
          end else begin
            cmd_o.op_top    = CELL_DOWN;
            cmd_o.op_second = CELL_DOWN;
            cmd_o.op_rest   = CELL_DOWN;
            cmd_o.feed      = top_i;
            sp_d            = sp_q + 1'b1;
          end
        end
        ACT_SWAP: begin
          if (sp_q >= SpW'(2)) begin
            cmd_o.op_top    = CELL_UP;
            cmd_o.op_second = CELL_DOWN;
          end else begin
            // short stack: old top (if any) moves down, zero lands on top;
            // an empty stack gets zero in the second slot as well
            res_o.status    = ST_EMPTY;
            cmd_o.op_top    = CELL_DOWN;
            cmd_o.op_second = empty ? CELL_ZERO : CELL_DOWN;
            cmd_o.op_rest   = CELL_DOWN;
            sp_d            = SpW'(2);
          end
        end
        ACT_CLEAR: begin
          sp_d = '0;
        end
        default: begin
        end
      endcase
    end
    // depth wraps to the output width on deep stacks
    res_o.depth = DepthW'(sp_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/value_stack_with_dup_swap.sv */
// value_stack_with_dup_swap: lifo stack of 64-bit values built as a row of cells
// depends on stk_pkg, stk_if, stk_cell, stk_ctrl
//
//   channel  dir  payload                          beat taken when
//   in_i     in   action[2:0], push_value[63:0]    in_i.valid && in_i.ready
//   out_o    out  read_value[63:0], status, depth  out_o.valid && out_o.ready
//
// one action beat per cycle while no result is stalled; its result beat appears the cycle after acceptance
// every action is finished in the cycle it is accepted: the cell row shifts at most once
// reset clears the stack pointer and the result valid flag; result data and cell contents are not reset
// a stalled result holds in the output register; a new action is taken in the same
// cycle the waiting result is taken
`timescale 1ns / 1ps
`default_nettype none

module value_stack_with_dup_swap import stk_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stk_in_if.sink    in_i,
  stk_out_if.source out_o
);

  // cell 0 is the top of stack, cell k the entry k places below it
  logic [ValueW-1:0] cell_data [STACK_DEPTH];
  cmd_t              cmd;
  res_t              res;
  res_t              res_q;
  logic              out_valid_q;
  logic              accept;

  // the result register frees up when it is empty or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  stk_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .action_i     (in_i.action),
    .push_value_i (in_i.push_value),
    .top_i        (cell_data[0]),
    .cmd_o        (cmd),
    .res_o        (res)
  );

  // row of cells; the top takes the feed value on a shift down, the bottom
  // cell refills from itself on a shift up (that slot is then unused)
  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    cell_op_e          op;
    logic [ValueW-1:0] above;
    logic [ValueW-1:0] below;

    if (k == 0) begin : g_top
      assign op    = cmd.op_top;
      assign above = cmd.feed;
    end else if (k == 1) begin : g_second
      assign op    = cmd.op_second;
      assign above = cell_data[k-1];
    end else begin : g_rest
      assign op    = cmd.op_rest;
      assign above = cell_data[k-1];
    end

    if (k == STACK_DEPTH - 1) begin : g_bottom
      assign below = cell_data[k];
    end else begin : g_inner
      assign below = cell_data[k+1];
    end

    stk_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .above_i (above),
      .below_i (below),
      .data_o  (cell_data[k])
    );
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = res_q.read_value;
  assign out_o.status     = res_q.status;
  assign out_o.depth      = res_q.depth;

endmodule

`default_nettype wire

/* tb/value_stack_with_dup_swap_tb.sv */
// value_stack_with_dup_swap_tb: self-checking bench for the 64-bit value stack
// drives action beats, predicts each result beat with a shadow stack and compares
// depends on stk_pkg, stk_in_if, stk_out_if and value_stack_with_dup_swap
`timescale 1ns / 1ps

module value_stack_with_dup_swap_tb;
  import stk_pkg::*;

  localparam int unsigned Depth        = StackDepthDef;
  localparam int unsigned ClkHalf      = 5;
  localparam int unsigned ResetCycles  = 8;
  localparam int unsigned RandomBeats  = 1550;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned MaxReported  = 10;
  // slowest legal run, with the longest gaps and stalls, stays well under this limit
  localparam int unsigned CycleLimit   = 250000;

  // codes outside action_e; the block must treat them as no-ops
  localparam logic [ActionW-1:0] ActSpareLo = 3'd6;
  localparam logic [ActionW-1:0] ActSpareHi = 3'd7;

  typedef struct {
    logic [ActionW-1:0] action;
    logic [ValueW-1:0]  value;
    bit                 drain;   // hold this beat back until no result is awaited
  } action_beat_t;

  logic clk_i;
  logic rst_ni;

  stk_in_if  in_bus ();
  stk_out_if out_bus ();

  value_stack_with_dup_swap #(
    .STACK_DEPTH (Depth)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // shadow stack: own copy of the entries and the pointer
  // ---------------------------------------------------------------------------
  logic [ValueW-1:0] shadow_entries [Depth];
  int unsigned       shadow_sp;

  function automatic status_e shadow_push(input logic [ValueW-1:0] v);
    if (shadow_sp < Depth) begin
      shadow_entries[shadow_sp] = v;
      shadow_sp++;
      return ST_OK;
    end
    return ST_FULL;   // full: value dropped, pointer untouched
  endfunction

  function automatic status_e shadow_pop(output logic [ValueW-1:0] v);
    if (shadow_sp > 0) begin
      shadow_sp--;
      v = shadow_entries[shadow_sp];
      return ST_OK;
    end
    v = '0;
    return ST_EMPTY;
  endfunction

  function automatic status_e shadow_peek(output logic [ValueW-1:0] v);
    if (shadow_sp > 0) begin
      v = shadow_entries[shadow_sp - 1];
      return ST_OK;
    end
    v = '0;
    return ST_EMPTY;
  endfunction

  // result beat that one action beat must produce; updates the shadow stack
  function automatic res_t stack_outcome(input logic [ActionW-1:0] act,
                                         input logic [ValueW-1:0]  val);
    res_t              r;
    logic [ValueW-1:0] upper_v;
    logic [ValueW-1:0] lower_v;
    status_e           s1;
    status_e           s2;
    r.read_value = '0;
    r.status     = ST_OK;
    case (act)
      ACT_PUSH: r.status = shadow_push(val);
      ACT_POP: begin
        r.status     = shadow_pop(upper_v);
        r.read_value = upper_v;
      end
      ACT_TOP: begin
        r.status     = shadow_peek(upper_v);
        r.read_value = upper_v;
      end
      ACT_DUP: begin
        // peek then push the peeked value; an empty stack pushes zero
        s1       = shadow_peek(upper_v);
        s2       = shadow_push(upper_v);
        r.status = (s1 != ST_OK) ? s1 : s2;
      end
      ACT_SWAP: begin
        // two pops then push them back in pop order; missing entries become zero
        s1 = shadow_pop(upper_v);
        s2 = shadow_pop(lower_v);
        void'(shadow_push(upper_v));
        void'(shadow_push(lower_v));
        r.status = (s1 != ST_OK || s2 != ST_OK) ? ST_EMPTY : ST_OK;
      end
      ACT_CLEAR: shadow_sp = 0;
      default: ;
    endcase
    r.depth = DepthW'(shadow_sp);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus store and bookkeeping
  // ---------------------------------------------------------------------------
  action_beat_t action_beats [$];
  res_t         awaited_results [$];
  action_beat_t beat_on_bus;
  int unsigned  queued_count;

  int unsigned  action_tally [8];
  int unsigned  full_drops;
  int unsigned  empty_hits;
  int unsigned  deepest;
  int unsigned  results_seen;
  int unsigned  mismatch_count;
  int unsigned  cycle_count;

  task automatic enqueue_beat(input logic [ActionW-1:0] act,
                              input logic [ValueW-1:0]  val,
                              input bit                 drain);
    action_beats.push_back('{action: act, value: val, drain: drain});
    queued_count++;
  endtask

  // mostly dense random words, with the corner patterns mixed in
  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] one_hot;
    one_hot = 64'd1 << $urandom_range(0, ValueW - 1);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // weighted towards push so the stack grows; spare codes stay rare
  function automatic logic [ActionW-1:0] pick_mixed_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 36) return ACT_PUSH;
    if (r < 58) return ACT_POP;
    if (r < 67) return ACT_TOP;
    if (r < 78) return ACT_DUP;
    if (r < 95) return ACT_SWAP;
    if (r < 98) return ACT_CLEAR;
    return (r == 98) ? ActSpareLo : ActSpareHi;
  endfunction

  // clear, fill to near full or past it, churn at the top, then pop past empty
  task automatic queue_fill_cycle(input bit drain);
    int unsigned n;
    enqueue_beat(ACT_CLEAR, pick_value(), drain);
    n = $urandom_range(Depth - 4, Depth + 8);
    repeat (n) enqueue_beat(($urandom_range(0, 7) == 0) ? ACT_DUP : ACT_PUSH,
                            pick_value(), 1'b0);
    repeat (12) enqueue_beat(pick_mixed_action(), pick_value(), 1'b0);
    n = $urandom_range(Depth + 2, Depth + 10);
    repeat (n) begin
      enqueue_beat(ACT_POP, pick_value(), 1'b0);
      if ($urandom_range(0, 9) == 0) enqueue_beat(ACT_TOP, pick_value(), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : drive_actions
    logic nxt_valid;
    res_t predicted;
    nxt_valid = in_bus.valid;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        // beat taken: run it through the shadow stack now
        predicted = stack_outcome(beat_on_bus.action, beat_on_bus.value);
        awaited_results.push_back(predicted);
        action_tally[beat_on_bus.action]++;
        if (predicted.status == ST_FULL)  full_drops++;
        if (predicted.status == ST_EMPTY) empty_hits++;
        if (predicted.depth > deepest)    deepest = predicted.depth;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (action_beats.size() != 0 &&
                     !(action_beats[0].drain && awaited_results.size() != 0)) begin
          beat_on_bus = action_beats.pop_front();
          nxt_valid   = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // now and then a long stretch with no idling at all
            if ($urandom_range(0, 7) == 0) begin
              burst_left = $urandom_range(100, 300);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 40);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
          end
        end
      end
    end
    in_bus.valid      <= nxt_valid;
    in_bus.action     <= beat_on_bus.action;
    in_bus.push_value <= beat_on_bus.value;
  end

  // ---------------------------------------------------------------------------
  // receiver: ready pattern switches between modes drawn at random, each with its own share of ready cycles
  // ---------------------------------------------------------------------------
  int unsigned ready_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin : watch_results
    res_t want;
    bit   nxt_ready;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported)
          $display("unexpected result beat %0d: value %h status %0d depth %0d",
                   results_seen, out_bus.read_value, out_bus.status, out_bus.depth);
      end else begin
        want = awaited_results.pop_front();
        if (out_bus.read_value !== want.read_value || out_bus.status !== want.status ||
            out_bus.depth !== want.depth) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported)
            $display("result beat %0d: value exp %h got %h, status exp %0d got %0d, %s",
                     results_seen, want.read_value, out_bus.read_value, want.status,
                     out_bus.status,
                     $sformatf("depth exp %0d got %0d", want.depth, out_bus.depth));
        end
      end
    end

    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    case (ready_mode)
      0: nxt_ready = 1'b1;
      1: nxt_ready = ($urandom_range(0, 3) != 0);
      2: nxt_ready = ($urandom_range(0, 2) == 0);
      default: begin
        // mostly ready, with occasional long stalls
        if (stall_left != 0) begin
          stall_left--;
          nxt_ready = 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(5, 20);
          nxt_ready  = 1'b0;
        end else begin
          nxt_ready = 1'b1;
        end
      end
    endcase
    out_bus.ready <= nxt_ready;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("run stopped at cycle %0d: %0d beats unsent, %0d results awaited",
               cycle_count, action_beats.size(), awaited_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    bit          drain_first;
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.action     = ACT_PUSH;
    in_bus.push_value = '0;
    out_bus.ready     = 1'b0;
    beat_on_bus       = '{action: ACT_PUSH, value: '0, drain: 1'b0};
    shadow_sp         = 0;

    // directed: empty-stack behaviour first, with junk in the ignored value
    enqueue_beat(ACT_POP,   64'hDEAD_BEEF_0123_4567, 1'b0);  // pop when empty
    enqueue_beat(ACT_TOP,   '1, 1'b0);                       // peek when empty
    enqueue_beat(ACT_SWAP,  64'h0F0F_0F0F_0F0F_0F0F, 1'b0);  // swap when empty: two zeros
    enqueue_beat(ACT_CLEAR, '0, 1'b0);
    enqueue_beat(ACT_DUP,   '1, 1'b0);                       // duplicate when empty: zero pushed
    enqueue_beat(ACT_CLEAR, '1, 1'b0);
    enqueue_beat(ACT_PUSH,  '1, 1'b0);
    enqueue_beat(ACT_SWAP,  '0, 1'b0);                       // swap on one entry: x then zero
    enqueue_beat(ACT_POP,   '0, 1'b0);
    enqueue_beat(ACT_POP,   '0, 1'b0);
    // value extremes and a swap with six entries held
    enqueue_beat(ACT_PUSH,  '0, 1'b0);
    enqueue_beat(ACT_PUSH,  64'h8000_0000_0000_0000, 1'b0);
    enqueue_beat(ACT_PUSH,  64'h0000_0000_0000_0001, 1'b0);
    enqueue_beat(ACT_PUSH,  64'h5555_5555_5555_5555, 1'b0);
    enqueue_beat(ACT_PUSH,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    enqueue_beat(ACT_TOP,   '0, 1'b0);
    enqueue_beat(ACT_DUP,   '0, 1'b0);
    enqueue_beat(ACT_SWAP,  '1, 1'b0);
    enqueue_beat(ACT_POP,   '0, 1'b0);
    enqueue_beat(ACT_POP,   '0, 1'b0);
    enqueue_beat(ActSpareLo, '1, 1'b0);                      // spare codes change nothing
    enqueue_beat(ActSpareHi, '1, 1'b0);
    enqueue_beat(ACT_CLEAR, '0, 1'b0);                       // clear with entries held
    enqueue_beat(ACT_TOP,   '0, 1'b0);

    // random part: the first segment always runs the stack to near full or past it and back
    // to empty, and waits for the directed results before it starts
    n = queued_count + RandomBeats;
    queue_fill_cycle(1'b1);
    while (queued_count < n) begin
      if ($urandom_range(0, 5) == 0) begin
        queue_fill_cycle($urandom_range(0, 3) == 0);
      end else begin
        drain_first = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(30, 120)) begin
          enqueue_beat(pick_mixed_action(), pick_value(), drain_first);
          drain_first = 1'b0;
        end
      end
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (action_beats.size() != 0 || in_bus.valid || awaited_results.size() != 0)
      @(posedge clk_i);
    // any stray result beat would show up here
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d action beats (push %0d pop %0d top %0d dup %0d swap %0d %s",
             queued_count, action_tally[ACT_PUSH], action_tally[ACT_POP],
             action_tally[ACT_TOP], action_tally[ACT_DUP], action_tally[ACT_SWAP],
             $sformatf("clear %0d spare %0d), %0d results checked",
                       action_tally[ACT_CLEAR],
                       action_tally[ActSpareLo] + action_tally[ActSpareHi],
                       results_seen));
    $display("full drops %0d, empty hits %0d, deepest stack %0d of %0d, %0d mismatches",
             full_drops, empty_hits, deepest, Depth, mismatch_count);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* value_stack_with_dup_swap.f */
hdl/stk_pkg.sv
hdl/stk_if.sv
hdl/stk_cell.sv
hdl/stk_ctrl.sv
hdl/value_stack_with_dup_swap.sv
tb/value_stack_with_dup_swap_tb.sv
